// ===== rtl/bgmc_pkg.sv =====
// ----------------------------------------------------------------------------
// bgmc_pkg
// Shared widths, event codes, register indexes and reset values for the
// button gesture and mode controller.
// ----------------------------------------------------------------------------
package bgmc_pkg;

  // Field widths
  localparam int OpcodeW  = 3;
  localparam int SampleW  = 24;
  localparam int TicksW   = 8;
  localparam int ByteW    = 8;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 24;
  localparam int PhaseW   = 2;

  // Bit position of the system status in the stored byte
  localparam int StatusBit = 7;

  // Event codes
  localparam logic [OpcodeW-1:0] OP_PRESS   = 3'd0;
  localparam logic [OpcodeW-1:0] OP_RELEASE = 3'd1;
  localparam logic [OpcodeW-1:0] OP_GAP     = 3'd2;
  localparam logic [OpcodeW-1:0] OP_TICK    = 3'd3;
  localparam logic [OpcodeW-1:0] OP_ENABLE  = 3'd4;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] REG_LONG_PRESS = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_FLOOR      = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_CEILING    = 2'd2;
  localparam logic [CfgAddrW-1:0] REG_MIDPOINT   = 2'd3;

  // Click phase codes; the unused code behaves as idle
  localparam logic [PhaseW-1:0] PH_IDLE    = 2'd0;
  localparam logic [PhaseW-1:0] PH_ONE     = 2'd1;
  localparam logic [PhaseW-1:0] PH_EXPIRED = 2'd2;

  // Register reset values
  localparam logic [TicksW-1:0]         LONG_PRESS_RST = 8'd6;
  localparam logic signed [SampleW-1:0] FLOOR_RST      = 24'sd0;
  localparam logic signed [SampleW-1:0] CEILING_RST    = 24'sd65535;
  localparam logic signed [SampleW-1:0] MIDPOINT_RST   = 24'sd32768;

  // Hold counter saturation value
  localparam logic [TicksW-1:0] TICKS_MAX = {TicksW{1'b1}};

endpackage

// ===== rtl/button_gesture_mode_controller.sv =====
// ----------------------------------------------------------------------------
// button_gesture_mode_controller
// Long press / double click detector driving mode, LED and peripheral
// enables, with sample clamping and a verbose flag in configuration mode.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | opcode, adc_sample, pin_level
//  out_    | output    | out_valid / out_stall| levels, store pulse/byte, pulses
//  cfg_    | input     | cfg_wr_en            | cfg_addr, cfg_wdata
//
//  Each request passes through the input register, then through the state
//  update into the result register.
//  A new request is accepted every cycle while results are taken.
//  Reset (rst_n low, synchronous) clears the valid flags and controller state and loads register defaults.
//  A stall on out_ holds the result; in_stall rises only when the input
//  register is full and the result register cannot advance.
// ----------------------------------------------------------------------------
module button_gesture_mode_controller
  import bgmc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_wr_en,
  input  logic [CfgAddrW-1:0]        cfg_addr,
  input  logic [CfgDataW-1:0]        cfg_wdata,
  // requests
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [OpcodeW-1:0]         in_opcode,
  input  logic signed [SampleW-1:0]  in_adc_sample,
  input  logic                       in_pin_level,
  // results
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_system_active,
  output logic                       out_config_active,
  output logic                       out_blue_led,
  output logic                       out_red_led,
  output logic                       out_spi_enable,
  output logic                       out_rgb_enable,
  output logic                       out_store_pulse,
  output logic [ByteW-1:0]           out_store_byte,
  output logic                       out_params_changed,
  output logic                       out_enable_changed
);

  // Configuration registers
  logic [TicksW-1:0]         long_press_r;
  logic signed [SampleW-1:0] floor_r;
  logic signed [SampleW-1:0] ceiling_r;
  logic signed [SampleW-1:0] midpoint_r;

  // Input register
  logic                      in_vld_r;
  logic [OpcodeW-1:0]        op_r;
  logic signed [SampleW-1:0] sample_r;
  logic                      pin_r;

  // Controller state
  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [TicksW-1:0] hold_r, hold_nxt;
  logic gap_run_r, gap_run_nxt;
  logic sys_r, sys_nxt;
  logic cfg_on_r, cfg_on_nxt;
  logic verbose_r, verbose_nxt;
  logic verbose_prev_r, verbose_prev_nxt;
  logic enable_r, enable_nxt;
  logic blue_r, blue_nxt;
  logic red_r, red_nxt;
  logic spi_r, spi_nxt;
  logic rgb_r, rgb_nxt;

  // Per-request outputs
  logic              store_nxt;
  logic [ByteW-1:0]  sbyte_nxt;
  logic              pchg_nxt;
  logic              echg_nxt;

  // Result register
  logic              out_vld_r;
  logic              out_sys_r, out_cfg_r, out_blue_r, out_red_r, out_spi_r, out_rgb_r;
  logic              out_store_r;
  logic [ByteW-1:0]  out_sbyte_r;
  logic              out_pchg_r, out_echg_r;

  logic                      s2_free;
  logic                      in_acc;
  logic                      advance;
  logic signed [SampleW-1:0] clamp_lo;
  logic signed [SampleW-1:0] clamped;
  logic                      verbose_cmp;

  // Handshake
  assign s2_free  = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !s2_free;
  assign in_acc   = in_valid && !in_stall;
  assign advance  = in_vld_r && s2_free;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= LONG_PRESS_RST;
      floor_r      <= FLOOR_RST;
      ceiling_r    <= CEILING_RST;
      midpoint_r   <= MIDPOINT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_LONG_PRESS: long_press_r <= cfg_wdata[TicksW-1:0];
        REG_FLOOR:      floor_r      <= cfg_wdata[SampleW-1:0];
        REG_CEILING:    ceiling_r    <= cfg_wdata[SampleW-1:0];
        REG_MIDPOINT:   midpoint_r   <= cfg_wdata[SampleW-1:0];
        default:        ;
      endcase
    end
  end

  // Input register: load on accept, drop when passed on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (s2_free) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= in_opcode;
      sample_r <= in_adc_sample;
      pin_r    <= in_pin_level;
    end
  end

  // Clamp the sample, floor first then ceiling, and compare with the midpoint
  always_comb begin
    clamp_lo    = (sample_r < floor_r) ? floor_r : sample_r;
    clamped     = (clamp_lo > ceiling_r) ? ceiling_r : clamp_lo;
    verbose_cmp = (clamped >= midpoint_r);
  end

  // Next state for one request
  always_comb begin
    phase_nxt        = phase_r;
    hold_nxt         = hold_r;
    gap_run_nxt      = gap_run_r;
    sys_nxt          = sys_r;
    cfg_on_nxt       = cfg_on_r;
    verbose_nxt      = verbose_r;
    verbose_prev_nxt = verbose_prev_r;
    enable_nxt       = enable_r;
    blue_nxt         = blue_r;
    red_nxt          = red_r;
    spi_nxt          = spi_r;
    rgb_nxt          = rgb_r;
    store_nxt        = 1'b0;
    sbyte_nxt        = '0;
    pchg_nxt         = 1'b0;
    echg_nxt         = 1'b0;

    unique case (op_r)
      OP_PRESS: begin
        gap_run_nxt = 1'b0;
        hold_nxt    = '0;
      end
      OP_RELEASE: begin
        if (hold_r >= long_press_r) begin
          // long press: toggle configuration mode
          if (!cfg_on_r) begin
            cfg_on_nxt = 1'b1;
            rgb_nxt    = 1'b0;
            spi_nxt    = 1'b0;
            sbyte_nxt  = '0;
          end else begin
            cfg_on_nxt = 1'b0;
            blue_nxt   = sys_r;
            if (sys_r) begin
              spi_nxt = 1'b1;
              rgb_nxt = 1'b1;
            end
            sbyte_nxt            = '0;
            sbyte_nxt[StatusBit] = sys_r;
          end
          sbyte_nxt[0] = verbose_r;
          store_nxt    = 1'b1;
          phase_nxt    = PH_IDLE;
        end else if (!cfg_on_r) begin
          if (phase_r == PH_ONE) begin
            // second short click: toggle acquisition
            sys_nxt              = !sys_r;
            blue_nxt             = !sys_r;
            spi_nxt              = !sys_r;
            rgb_nxt              = !sys_r;
            sbyte_nxt[StatusBit] = !sys_r;
            sbyte_nxt[0]         = verbose_r;
            store_nxt            = 1'b1;
            phase_nxt            = PH_IDLE;
          end else begin
            phase_nxt   = PH_ONE;
            gap_run_nxt = 1'b1;
          end
        end
      end
      OP_GAP: begin
        if (gap_run_r) begin
          phase_nxt = PH_EXPIRED;
        end
      end
      OP_TICK: begin
        if (hold_r != TICKS_MAX) begin
          hold_nxt = hold_r + 1'b1;
        end
        if (cfg_on_r) begin
          blue_nxt = !blue_r;
          if (enable_r) begin
            verbose_nxt      = verbose_cmp;
            red_nxt          = verbose_cmp;
            pchg_nxt         = (verbose_prev_r != verbose_cmp);
            verbose_prev_nxt = verbose_cmp;
          end
        end
      end
      OP_ENABLE: begin
        enable_nxt = pin_r;
        echg_nxt   = 1'b1;
      end
      default: ;
    endcase
  end

  // Commit state as the request moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      hold_r         <= '0;
      gap_run_r      <= 1'b0;
      sys_r          <= 1'b0;
      cfg_on_r       <= 1'b0;
      verbose_r      <= 1'b0;
      verbose_prev_r <= 1'b0;
      enable_r       <= 1'b0;
      blue_r         <= 1'b0;
      red_r          <= 1'b0;
      spi_r          <= 1'b0;
      rgb_r          <= 1'b0;
    end else if (advance) begin
      phase_r        <= phase_nxt;
      hold_r         <= hold_nxt;
      gap_run_r      <= gap_run_nxt;
      sys_r          <= sys_nxt;
      cfg_on_r       <= cfg_on_nxt;
      verbose_r      <= verbose_nxt;
      verbose_prev_r <= verbose_prev_nxt;
      enable_r       <= enable_nxt;
      blue_r         <= blue_nxt;
      red_r          <= red_nxt;
      spi_r          <= spi_nxt;
      rgb_r          <= rgb_nxt;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s2_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_sys_r   <= sys_nxt;
      out_cfg_r   <= cfg_on_nxt;
      out_blue_r  <= blue_nxt;
      out_red_r   <= red_nxt;
      out_spi_r   <= spi_nxt;
      out_rgb_r   <= rgb_nxt;
      out_store_r <= store_nxt;
      out_sbyte_r <= sbyte_nxt;
      out_pchg_r  <= pchg_nxt;
      out_echg_r  <= echg_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_system_active  = out_sys_r;
  assign out_config_active  = out_cfg_r;
  assign out_blue_led       = out_blue_r;
  assign out_red_led        = out_red_r;
  assign out_spi_enable     = out_spi_r;
  assign out_rgb_enable     = out_rgb_r;
  assign out_store_pulse    = out_store_r;
  assign out_store_byte     = out_sbyte_r;
  assign out_params_changed = out_pchg_r;
  assign out_enable_changed = out_echg_r;

  // Checks
  a_byte_only_on_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_store_r |-> out_sbyte_r == '0)
    else $error("store byte set without store pulse");

  a_pchg_in_config: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_pchg_r |-> out_cfg_r)
    else $error("verbose change outside configuration mode");

  a_config_entry_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_store_r && out_cfg_r |-> !out_spi_r && !out_rgb_r
      && !out_sbyte_r[StatusBit])
    else $error("peripherals left on when entering configuration mode");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_vld_r)
    else $error("input stalled with free pipeline");

endmodule

// ===== tb/sv/gesture_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gesture controller scoreboard
// Result record and scoreboard for the button gesture and mode controller.
// The scoreboard tracks the click, hold and mode state and the register
// settings. It works out the levels and pulses for each accepted request
// and checks every result against the oldest one still pending.
// ----------------------------------------------------------------------------
package gesture_tb_pkg;
  import bgmc_pkg::*;

  // Opcodes past the defined events; the block must leave its state alone
  localparam logic [OpcodeW-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OpcodeW-1:0] OP_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic              system_active;
    logic              config_active;
    logic              blue_led;
    logic              red_led;
    logic              spi_enable;
    logic              rgb_enable;
    logic              store_pulse;
    logic [ByteW-1:0]  store_byte;
    logic              params_changed;
    logic              enable_changed;
  } levels_t;

  class gesture_scoreboard;
    // register copies
    logic [TicksW-1:0]         long_press;
    logic signed [SampleW-1:0] clamp_lo;
    logic signed [SampleW-1:0] clamp_hi;
    logic signed [SampleW-1:0] midpoint;
    // gesture and mode state
    logic [PhaseW-1:0] click_phase;
    logic [TicksW-1:0] hold_ticks;
    logic gap_running, system_on, config_on, verbose, verbose_prev;
    logic enable_on, blue, red, spi_on, rgb_on;
    levels_t expected_levels[$];
    int errors;

    function new();
      long_press   = LONG_PRESS_RST;
      clamp_lo     = FLOOR_RST;
      clamp_hi     = CEILING_RST;
      midpoint     = MIDPOINT_RST;
      click_phase  = PH_IDLE;
      hold_ticks   = '0;
      gap_running  = 1'b0;
      system_on    = 1'b0;
      config_on    = 1'b0;
      verbose      = 1'b0;
      verbose_prev = 1'b0;
      enable_on    = 1'b0;
      blue         = 1'b0;
      red          = 1'b0;
      spi_on       = 1'b0;
      rgb_on       = 1'b0;
      errors       = 0;
    endfunction

    function void write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_LONG_PRESS: long_press = data[TicksW-1:0];
        REG_FLOOR:      clamp_lo = data;
        REG_CEILING:    clamp_hi = data;
        REG_MIDPOINT:   midpoint = data;
        default: ;
      endcase
    endfunction

    function logic [ByteW-1:0] status_byte(logic sys);
      logic [ByteW-1:0] b;
      b = '0;
      b[StatusBit] = sys;
      b[0] = verbose;
      return b;
    endfunction

    // Advance the state by one request and queue the levels it leads to
    function void note_request(logic [OpcodeW-1:0] op, logic signed [SampleW-1:0] sample,
                               logic pin);
      levels_t r;
      logic signed [SampleW-1:0] s;
      r = '0;
      s = sample;
      case (op)
        OP_PRESS: begin
          gap_running = 1'b0;
          hold_ticks = '0;
        end
        OP_RELEASE: begin
          if (hold_ticks >= long_press) begin
            // long press flips configuration mode
            if (!config_on) begin
              config_on = 1'b1;
              r.store_byte = status_byte(1'b0);
              rgb_on = 1'b0;
              spi_on = 1'b0;
            end else begin
              config_on = 1'b0;
              blue = system_on;
              if (system_on) begin
                spi_on = 1'b1;
                rgb_on = 1'b1;
              end
              r.store_byte = status_byte(system_on);
            end
            r.store_pulse = 1'b1;
            click_phase = PH_IDLE;
          end else if (!config_on) begin
            // second short click flips acquisition
            if (click_phase == PH_ONE) begin
              system_on = !system_on;
              blue = system_on;
              spi_on = system_on;
              rgb_on = system_on;
              r.store_byte = status_byte(system_on);
              r.store_pulse = 1'b1;
              click_phase = PH_IDLE;
            end else begin
              click_phase = PH_ONE;
              gap_running = 1'b1;
            end
          end
        end
        OP_GAP: begin
          if (gap_running) click_phase = PH_EXPIRED;
        end
        OP_TICK: begin
          if (hold_ticks != TICKS_MAX) hold_ticks++;
          if (config_on) begin
            blue = !blue;
            // floor first, so the ceiling wins when they cross
            if (s < clamp_lo) s = clamp_lo;
            if (s > clamp_hi) s = clamp_hi;
            if (enable_on) begin
              verbose = (s >= midpoint);
              red = verbose;
              r.params_changed = (verbose_prev != verbose);
              verbose_prev = verbose;
            end
          end
        end
        OP_ENABLE: begin
          enable_on = pin;
          r.enable_changed = 1'b1;
        end
        default: ;
      endcase
      r.system_active = system_on;
      r.config_active = config_on;
      r.blue_led      = blue;
      r.red_led       = red;
      r.spi_enable    = spi_on;
      r.rgb_enable    = rgb_on;
      expected_levels.push_back(r);
    endfunction

    function void compare_field(string name, logic [ByteW-1:0] want, logic [ByteW-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    // Check one result against the oldest pending request
    function void check_levels(levels_t got);
      levels_t want;
      if (expected_levels.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, expected none actual %h",
                 $time, got);
        return;
      end
      want = expected_levels.pop_front();
      compare_field("system_active", ByteW'(want.system_active), ByteW'(got.system_active));
      compare_field("config_active", ByteW'(want.config_active), ByteW'(got.config_active));
      compare_field("blue_led", ByteW'(want.blue_led), ByteW'(got.blue_led));
      compare_field("red_led", ByteW'(want.red_led), ByteW'(got.red_led));
      compare_field("spi_enable", ByteW'(want.spi_enable), ByteW'(got.spi_enable));
      compare_field("rgb_enable", ByteW'(want.rgb_enable), ByteW'(got.rgb_enable));
      compare_field("store_pulse", ByteW'(want.store_pulse), ByteW'(got.store_pulse));
      compare_field("store_byte", want.store_byte, got.store_byte);
      compare_field("params_changed", ByteW'(want.params_changed),
                    ByteW'(got.params_changed));
      compare_field("enable_changed", ByteW'(want.enable_changed),
                    ByteW'(got.enable_changed));
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gesture controller testbench
// Drives button, tick and enable-pin requests into the controller, first a
// short directed sequence and then random gestures under several register
// settings. The input idles and the output stalls in random bursts. Every result is
// checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
  import bgmc_pkg::*;
  import gesture_tb_pkg::*;

  localparam int QuietLimit = 1000;

  logic clk, rst_n;
  logic cfg_wr_en;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;
  logic in_valid, in_stall;
  logic [OpcodeW-1:0] in_opcode;
  logic signed [SampleW-1:0] in_adc_sample;
  logic in_pin_level;
  logic out_valid, out_stall;
  logic out_system_active, out_config_active, out_blue_led, out_red_led;
  logic out_spi_enable, out_rgb_enable, out_store_pulse;
  logic [ByteW-1:0] out_store_byte;
  logic out_params_changed, out_enable_changed;

  gesture_scoreboard board;
  bit idle_on = 1'b1;
  bit send_quiet = 1'b0;
  int events_sent = 0;
  int stall_left = 0;
  int calm_left = 0;
  int quiet_cycles = 0;

  button_gesture_mode_controller uut (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Take results, check them, and stall in random bursts
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_levels({out_system_active, out_config_active, out_blue_led, out_red_led,
                          out_spi_enable, out_rgb_enable, out_store_pulse, out_store_byte,
                          out_params_changed, out_enable_changed});
    if (calm_left > 0) begin
      calm_left--;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (idle_on) begin
      case ($urandom_range(0, 7))
        0: stall_left = $urandom_range(1, 6);
        1: calm_left = $urandom_range(10, 40);
        default: ;
      endcase
    end
    out_stall <= (stall_left > 0);
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request, hold it until accepted, then note it
  task automatic send_request(logic [OpcodeW-1:0] op, logic signed [SampleW-1:0] sample,
                              logic pin);
    if (idle_on && !send_quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_adc_sample <= sample;
    in_pin_level <= pin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(op, sample, pin);
    events_sent++;
  endtask

  task automatic press_button();
    send_request(OP_PRESS, SampleW'($urandom), 1'($urandom));
  endtask

  task automatic release_button();
    send_request(OP_RELEASE, SampleW'($urandom), 1'($urandom));
  endtask

  task automatic gap_timeout();
    send_request(OP_GAP, SampleW'($urandom), 1'($urandom));
  endtask

  task automatic tick(logic signed [SampleW-1:0] sample);
    send_request(OP_TICK, sample, 1'($urandom));
  endtask

  task automatic set_enable(logic pin);
    send_request(OP_ENABLE, SampleW'($urandom), pin);
  endtask

  // Samples mostly land near the clamp limits and the midpoint
  function automatic logic signed [SampleW-1:0] pick_sample();
    int delta;
    delta = int'($urandom_range(0, 8)) - 4;
    case ($urandom_range(0, 3))
      0: return SampleW'(int'(board.clamp_lo) + delta);
      1: return SampleW'(int'(board.clamp_hi) + delta);
      2: return SampleW'(int'(board.midpoint) + delta);
      default: return SampleW'($urandom);
    endcase
  endfunction

  // Hold length that stays below a nonzero long press threshold, kept short
  function automatic int short_hold();
    int top;
    top = int'(board.long_press) - 1;
    if (top > 3) top = 3;
    return (top > 0) ? int'($urandom_range(0, top)) : 0;
  endfunction

  task automatic hold_button(int ticks);
    press_button();
    repeat (ticks) tick(pick_sample());
    release_button();
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] idx, int data);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= CfgDataW'(data);
    @(posedge clk);
    board.write_reg(idx, CfgDataW'(data));
  endtask

  // Reprogram all registers once the block has gone idle
  task automatic configure(int long_press, int lo, int hi, int mid);
    drain();
    repeat (2) @(posedge clk);
    write_reg(REG_LONG_PRESS, long_press);
    write_reg(REG_FLOOR, lo);
    write_reg(REG_CEILING, hi);
    write_reg(REG_MIDPOINT, mid);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Random gestures, mostly well formed, with some noise and pauses
  task automatic run_gestures(int count);
    int stop;
    stop = events_sent + count;
    while (events_sent < stop) begin
      send_quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1: begin
          // double click
          hold_button(short_hold());
          if ($urandom_range(0, 1) == 1) tick(pick_sample());
          hold_button(short_hold());
        end
        2: begin
          if (board.long_press <= 8'd16)
            hold_button(int'(board.long_press) + int'($urandom_range(0, 2)));
          else
            hold_button(short_hold());
        end
        3: begin
          // click, timeout, click: no toggle
          hold_button(short_hold());
          gap_timeout();
          hold_button(short_hold());
        end
        4, 5: repeat ($urandom_range(1, 6)) tick(pick_sample());
        6: set_enable($urandom_range(0, 3) != 0);
        7: begin
          hold_button(short_hold());
          gap_timeout();
        end
        8: send_request(OpcodeW'($urandom_range(OP_PRESS, OP_SPARE_LAST)),
                        SampleW'($urandom), 1'($urandom));
        default: drain();
      endcase
    end
  endtask

  initial begin
    board = new();
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_addr <= REG_LONG_PRESS;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_opcode <= OP_PRESS;
    in_adc_sample <= '0;
    in_pin_level <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset register values
    set_enable(1'b1);
    hold_button(0);
    hold_button(0);
    hold_button(int'(LONG_PRESS_RST));
    tick(24'sh7FFFFF);
    tick(24'sh800000);
    tick(MIDPOINT_RST);
    // timeout with the gap timer stopped, then a short release in config mode
    press_button();
    gap_timeout();
    release_button();
    for (int op = int'(OP_SPARE_FIRST); op <= int'(OP_SPARE_LAST); op++)
      send_request(OpcodeW'(op), SampleW'($urandom), 1'($urandom));

    // Widest clamp window
    configure(1, -8388608, 8388607, 0);
    run_gestures(25);
    // Floor above ceiling
    configure(3, 1000, -1000, int'($urandom_range(0, 4000)) - 2000);
    run_gestures(20);
    // Highest threshold; one hold long enough to saturate the counter
    configure(255, int'($urandom), int'($urandom), int'($urandom));
    hold_button(260);
    run_gestures(10);
    // Zero threshold: every release is long
    configure(0, 0, 8388607, 8388607);
    run_gestures(20);
    // Final stretch at full rate
    idle_on = 1'b0;
    configure(4, -100, 100, -8388608);
    run_gestures(40);

    drain();
    repeat (4) @(posedge clk);
    if (board.pending() != 0) begin
      board.errors++;
      $display("%0t: pending results expected 0 actual %0d", $time, board.pending());
    end
    if (board.errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
